/* design/wide_line_quad_expander_macros.svh */
// Assertion macros for the wide line quad expander.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef WIDE_LINE_QUAD_EXPANDER_MACROS_SVH
`define WIDE_LINE_QUAD_EXPANDER_MACROS_SVH

// Condition a in a cycle implies condition b in the same cycle.
`define WLQE_ASSERT_SAME(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("wlqe: same-cycle check failed");

// Condition a in a cycle implies condition b in the next cycle.
`define WLQE_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("wlqe: next-cycle check failed");

`endif

/* design/wlqe_pkg.sv */
// Types, codes and helpers shared by the wide line quad expander.
// No dependencies.
package wlqe_pkg;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic [30:0]        line_width;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         vertex_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic               tex_u;
        logic               tex_v;
        logic signed [31:0] mid_x;
        logic signed [31:0] mid_y;
        logic               last_vertex;
    } t_out_item;

    // Segment data that travels alongside the arithmetic.
    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic [29:0]        h;
        logic [30:0]        ax;
        logic [30:0]        ay;
        logic               neg_dx;
        logic               neg_dy;
        logic               zero;
    } t_side;

    // One divider lane: partial remainder and dividend bits turning into quotient.
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] acc;
    } t_div_lane;

    localparam logic [2:0] VTX_BR0 = 3'd0;
    localparam logic [2:0] VTX_TR  = 3'd1;
    localparam logic [2:0] VTX_TL0 = 3'd2;
    localparam logic [2:0] VTX_BR1 = 3'd3;
    localparam logic [2:0] VTX_BL  = 3'd4;
    localparam logic [2:0] VTX_TL1 = 3'd5;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;
    localparam int NORM_STEPS = 5;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* design/wlqe_norm_cell.sv */
// One step of the magnitude normaliser: shift left by SHIFT when room allows.
// Depends on wlqe_pkg.
module wlqe_norm_cell #(
    parameter int SHIFT = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  wlqe_pkg::t_side  i_side,
    output logic             o_valid,
    output wlqe_pkg::t_side  o_side
);
    logic [30:0]     m;
    logic            do_shift;
    wlqe_pkg::t_side n_side;

    always_comb begin
        m        = i_side.ax | i_side.ay;
        do_shift = (m >> (31 - SHIFT)) == 31'd0;
        n_side   = i_side;
        if (do_shift) begin
            n_side.ax = i_side.ax << SHIFT;
            n_side.ay = i_side.ay << SHIFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_side <= n_side;
    end
endmodule

/* design/wlqe_sqrt_cell.sv */
// One bit of the integer square root: trial subtract at bit 2*(31-STEP).
// Depends on wlqe_pkg.
module wlqe_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  wlqe_pkg::t_side  i_side,
    input  logic [62:0]      i_n,
    input  logic [62:0]      i_res,
    output logic             o_valid,
    output wlqe_pkg::t_side  o_side,
    output logic [62:0]      o_n,
    output logic [62:0]      o_res
);
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    logic [63:0] trial;
    logic [62:0] n_n;
    logic [62:0] n_res;

    always_comb begin
        trial = {1'b0, i_res} + BIT;
        if ({1'b0, i_n} >= trial) begin
            n_n   = i_n - trial[62:0];
            n_res = (i_res >> 1) + BIT[62:0];
        end else begin
            n_n   = i_n;
            n_res = i_res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_side <= i_side;
        o_n    <= n_n;
        o_res  <= n_res;
    end
endmodule

/* design/wlqe_div_cell.sv */
// One quotient bit for both offset dividers, sharing the divisor.
// Depends on wlqe_pkg.
module wlqe_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  wlqe_pkg::t_side     i_side,
    input  logic [31:0]         i_len,
    input  wlqe_pkg::t_div_lane i_lx,
    input  wlqe_pkg::t_div_lane i_ly,
    output logic                o_valid,
    output wlqe_pkg::t_side     o_side,
    output logic [31:0]         o_len,
    output wlqe_pkg::t_div_lane o_lx,
    output wlqe_pkg::t_div_lane o_ly
);
    function automatic wlqe_pkg::t_div_lane step(input wlqe_pkg::t_div_lane l,
                                                 input logic [31:0] d);
        logic [32:0]         r2;
        logic                ge;
        wlqe_pkg::t_div_lane o;
        r2    = {l.rem, l.acc[31]};
        ge    = r2 >= {1'b0, d};
        o.rem = ge ? 32'(r2 - {1'b0, d}) : r2[31:0];
        o.acc = {l.acc[30:0], ge};
        return o;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_side <= i_side;
        o_len  <= i_len;
        o_lx   <= step(i_lx, i_len);
        o_ly   <= step(i_ly, i_len);
    end
endmodule

/* design/wide_line_quad_expander.sv */
// Top level of the wide line quad expander: input stage, normaliser, root and
// divider cell chains, corner stage and vertex sequencer.
// Depends on wlqe_pkg, the three cell modules and the macros header.
//
// Usage:
//   A segment transaction is taken when start is high and busy is low. Each
//   segment yields six vertex transactions on o_result, one per cycle while
//   o_strobe is high, in the order BR, TR, TL, BR, BL, TL; the sixth carries
//   the diagonal midpoint and last_vertex.
//   The first vertex is registered through the input, difference, range,
//   normaliser, square, sum, root, numerator, divider, corner and sequencer
//   stages; the six vertices follow in consecutive cycles. busy spaces
//   acceptances to match the single result port, which emits one vertex per
//   cycle; the normaliser, the 32-cell square-root chain and the 32-cell
//   divider chain are fully pipelined and hold several segments at once.
//   Reset (synchronous, active low) empties the pipeline and drops any
//   vertices still to be emitted.
//   The receiver cannot stall: every strobed vertex is taken in its cycle.
`include "wide_line_quad_expander_macros.svh"

module wide_line_quad_expander (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  wlqe_pkg::t_in_item  i_item,
    output logic                o_strobe,
    output wlqe_pkg::t_out_item o_result
);
    // acceptance and spacing
    logic       accept;
    logic [2:0] r_gap;
    logic [2:0] n_gap;

    assign busy   = r_gap != 3'd0;
    assign accept = start && !busy;

    always_comb begin
        n_gap = r_gap;
        if (accept) begin
            n_gap = 3'd5;
        end else if (r_gap != 3'd0) begin
            n_gap = r_gap - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= 3'd0;
        end else begin
            r_gap <= n_gap;
        end
    end

    // input register
    logic               r_v0;
    wlqe_pkg::t_in_item r_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_item;
        end
    end

    // differences and magnitudes
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [32:0]        adx;
    logic [32:0]        ady;
    logic               r_v1;
    wlqe_pkg::t_side    r_s1;
    logic [31:0]        r_ax1;
    logic [31:0]        r_ay1;

    always_comb begin
        dx  = {r_in.end_x[31], r_in.end_x} - {r_in.start_x[31], r_in.start_x};
        dy  = {r_in.end_y[31], r_in.end_y} - {r_in.start_y[31], r_in.start_y};
        adx = dx[32] ? 33'(-dx) : dx;
        ady = dy[32] ? 33'(-dy) : dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1.sx     <= r_in.start_x;
        r_s1.sy     <= r_in.start_y;
        r_s1.ex     <= r_in.end_x;
        r_s1.ey     <= r_in.end_y;
        r_s1.h      <= r_in.line_width[30:1];
        r_s1.ax     <= 31'd0;
        r_s1.ay     <= 31'd0;
        r_s1.neg_dx <= dx[32];
        r_s1.neg_dy <= dy[32];
        r_s1.zero   <= (dx == 33'sd0) && (dy == 33'sd0);
        r_ax1       <= adx[31:0];
        r_ay1       <= ady[31:0];
    end

    // bring the larger magnitude below 2^31
    logic            r_v2;
    wlqe_pkg::t_side r_s2;
    wlqe_pkg::t_side n_s2;

    always_comb begin
        n_s2 = r_s1;
        if (r_ax1[31] || r_ay1[31]) begin
            n_s2.ax = r_ax1[31:1];
            n_s2.ay = r_ay1[31:1];
        end else begin
            n_s2.ax = r_ax1[30:0];
            n_s2.ay = r_ay1[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2 <= n_s2;
    end

    // normaliser chain: shifts of 16, 8, 4, 2, 1
    logic            nv [wlqe_pkg::NORM_STEPS+1];
    wlqe_pkg::t_side ns [wlqe_pkg::NORM_STEPS+1];

    assign nv[0] = r_v2;
    assign ns[0] = r_s2;

    for (genvar g = 0; g < wlqe_pkg::NORM_STEPS; g++) begin : g_norm
        wlqe_norm_cell #(
            .SHIFT(16 >> g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(nv[g]),
            .i_side (ns[g]),
            .o_valid(nv[g+1]),
            .o_side (ns[g+1])
        );
    end

    // squares as 16-bit partial products
    wlqe_pkg::t_side sn;
    logic            r_v8;
    wlqe_pkg::t_side r_s8;
    logic [29:0]     r_xhh;
    logic [30:0]     r_xhl;
    logic [31:0]     r_xll;
    logic [29:0]     r_yhh;
    logic [30:0]     r_yhl;
    logic [31:0]     r_yll;

    assign sn = ns[wlqe_pkg::NORM_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
        end else begin
            r_v8 <= nv[wlqe_pkg::NORM_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s8  <= sn;
        r_xhh <= sn.ax[30:16] * sn.ax[30:16];
        r_xhl <= sn.ax[30:16] * sn.ax[15:0];
        r_xll <= sn.ax[15:0] * sn.ax[15:0];
        r_yhh <= sn.ay[30:16] * sn.ay[30:16];
        r_yhl <= sn.ay[30:16] * sn.ay[15:0];
        r_yll <= sn.ay[15:0] * sn.ay[15:0];
    end

    // sum of squares
    logic            r_v9;
    wlqe_pkg::t_side r_s9;
    logic [62:0]     r_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v9 <= 1'b0;
        end else begin
            r_v9 <= r_v8;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s9 <= r_s8;
        r_sq <= ({1'b0, r_xhh, 32'd0} + {15'd0, r_xhl, 17'd0} + {31'd0, r_xll})
              + ({1'b0, r_yhh, 32'd0} + {15'd0, r_yhl, 17'd0} + {31'd0, r_yll});
    end

    // square-root chain
    logic            qv [wlqe_pkg::SQRT_STEPS+1];
    wlqe_pkg::t_side qs [wlqe_pkg::SQRT_STEPS+1];
    logic [62:0]     qn [wlqe_pkg::SQRT_STEPS+1];
    logic [62:0]     qr [wlqe_pkg::SQRT_STEPS+1];

    assign qv[0] = r_v9;
    assign qs[0] = r_s9;
    assign qn[0] = r_sq;
    assign qr[0] = 63'd0;

    for (genvar g = 0; g < wlqe_pkg::SQRT_STEPS; g++) begin : g_sqrt
        wlqe_sqrt_cell #(
            .STEP(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(qv[g]),
            .i_side (qs[g]),
            .i_n    (qn[g]),
            .i_res  (qr[g]),
            .o_valid(qv[g+1]),
            .o_side (qs[g+1]),
            .o_n    (qn[g+1]),
            .o_res  (qr[g+1])
        );
    end

    // offset numerators as partial products
    wlqe_pkg::t_side sq_side;
    logic            r_vm1;
    wlqe_pkg::t_side r_sm1;
    logic [31:0]     r_len1;
    logic [45:0]     r_pxl;
    logic [44:0]     r_pxh;
    logic [45:0]     r_pyl;
    logic [44:0]     r_pyh;

    assign sq_side = qs[wlqe_pkg::SQRT_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm1 <= 1'b0;
        end else begin
            r_vm1 <= qv[wlqe_pkg::SQRT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sm1  <= sq_side;
        r_len1 <= qr[wlqe_pkg::SQRT_STEPS][31:0];
        r_pxl  <= sq_side.h * sq_side.ay[15:0];
        r_pxh  <= sq_side.h * sq_side.ay[30:16];
        r_pyl  <= sq_side.h * sq_side.ax[15:0];
        r_pyh  <= sq_side.h * sq_side.ax[30:16];
    end

    // numerators with half-length rounding, split for the dividers
    logic [61:0]         numx;
    logic [61:0]         numy;
    logic                r_vm2;
    wlqe_pkg::t_side     r_sm2;
    logic [31:0]         r_len2;
    wlqe_pkg::t_div_lane r_lx;
    wlqe_pkg::t_div_lane r_ly;

    always_comb begin
        numx = {1'b0, r_pxh, 16'd0} + {16'd0, r_pxl} + {31'd0, r_len1[31:1]};
        numy = {1'b0, r_pyh, 16'd0} + {16'd0, r_pyl} + {31'd0, r_len1[31:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm2 <= 1'b0;
        end else begin
            r_vm2 <= r_vm1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sm2      <= r_sm1;
        r_len2     <= r_len1;
        r_lx.rem   <= {2'd0, numx[61:32]};
        r_lx.acc   <= numx[31:0];
        r_ly.rem   <= {2'd0, numy[61:32]};
        r_ly.acc   <= numy[31:0];
    end

    // divider chain
    logic                dv [wlqe_pkg::DIV_STEPS+1];
    wlqe_pkg::t_side     ds [wlqe_pkg::DIV_STEPS+1];
    logic [31:0]         dl [wlqe_pkg::DIV_STEPS+1];
    wlqe_pkg::t_div_lane dx_l [wlqe_pkg::DIV_STEPS+1];
    wlqe_pkg::t_div_lane dy_l [wlqe_pkg::DIV_STEPS+1];

    assign dv[0]   = r_vm2;
    assign ds[0]   = r_sm2;
    assign dl[0]   = r_len2;
    assign dx_l[0] = r_lx;
    assign dy_l[0] = r_ly;

    for (genvar g = 0; g < wlqe_pkg::DIV_STEPS; g++) begin : g_div
        wlqe_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(dv[g]),
            .i_side (ds[g]),
            .i_len  (dl[g]),
            .i_lx   (dx_l[g]),
            .i_ly   (dy_l[g]),
            .o_valid(dv[g+1]),
            .o_side (ds[g+1]),
            .o_len  (dl[g+1]),
            .o_lx   (dx_l[g+1]),
            .o_ly   (dy_l[g+1])
        );
    end

    // offset and saturated corners
    wlqe_pkg::t_side    dside;
    logic signed [31:0] mxm;
    logic signed [31:0] mym;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic               r_vc;
    logic signed [31:0] r_brx, r_bry, r_blx, r_bly, r_trx, r_try, r_tlx, r_tly;

    assign dside = ds[wlqe_pkg::DIV_STEPS];
    assign mxm   = dx_l[wlqe_pkg::DIV_STEPS].acc;
    assign mym   = dy_l[wlqe_pkg::DIV_STEPS].acc;

    always_comb begin
        if (dside.zero) begin
            ox = 32'sd0;
            oy = -$signed({2'd0, dside.h});
        end else begin
            ox = dside.neg_dy ? -mxm : mxm;
            oy = dside.neg_dx ? mym : -mym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else begin
            r_vc <= dv[wlqe_pkg::DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_brx <= wlqe_pkg::sat33({dside.sx[31], dside.sx} + {ox[31], ox});
        r_bry <= wlqe_pkg::sat33({dside.sy[31], dside.sy} + {oy[31], oy});
        r_blx <= wlqe_pkg::sat33({dside.sx[31], dside.sx} - {ox[31], ox});
        r_bly <= wlqe_pkg::sat33({dside.sy[31], dside.sy} - {oy[31], oy});
        r_trx <= wlqe_pkg::sat33({dside.ex[31], dside.ex} + {ox[31], ox});
        r_try <= wlqe_pkg::sat33({dside.ey[31], dside.ey} + {oy[31], oy});
        r_tlx <= wlqe_pkg::sat33({dside.ex[31], dside.ex} - {ox[31], ox});
        r_tly <= wlqe_pkg::sat33({dside.ey[31], dside.ey} - {oy[31], oy});
    end

    // vertex sequencer: load a quad, emit six vertices
    logic signed [32:0] msx;
    logic signed [32:0] msy;
    logic               r_act;
    logic [2:0]         r_idx;
    logic signed [31:0] r_qbrx, r_qbry, r_qblx, r_qbly;
    logic signed [31:0] r_qtrx, r_qtry, r_qtlx, r_qtly;
    logic signed [31:0] r_midx, r_midy;

    assign msx = {r_tlx[31], r_tlx} + {r_brx[31], r_brx};
    assign msy = {r_tly[31], r_tly} + {r_bry[31], r_bry};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_idx <= wlqe_pkg::VTX_BR0;
        end else if (r_vc) begin
            r_act <= 1'b1;
            r_idx <= wlqe_pkg::VTX_BR0;
        end else if (r_act) begin
            if (r_idx == wlqe_pkg::VTX_TL1) begin
                r_act <= 1'b0;
                r_idx <= wlqe_pkg::VTX_BR0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vc) begin
            r_qbrx <= r_brx;
            r_qbry <= r_bry;
            r_qblx <= r_blx;
            r_qbly <= r_bly;
            r_qtrx <= r_trx;
            r_qtry <= r_try;
            r_qtlx <= r_tlx;
            r_qtly <= r_tly;
            r_midx <= msx[32:1];
            r_midy <= msy[32:1];
        end
    end

    always_comb begin
        o_strobe              = r_act;
        o_result.vertex_index = r_idx;
        o_result.mid_x        = 32'sd0;
        o_result.mid_y        = 32'sd0;
        o_result.last_vertex  = 1'b0;
        unique case (r_idx)
            wlqe_pkg::VTX_BR0, wlqe_pkg::VTX_BR1: begin
                o_result.pos_x = r_qbrx;
                o_result.pos_y = r_qbry;
                o_result.tex_u = 1'b1;
                o_result.tex_v = 1'b0;
            end
            wlqe_pkg::VTX_TR: begin
                o_result.pos_x = r_qtrx;
                o_result.pos_y = r_qtry;
                o_result.tex_u = 1'b1;
                o_result.tex_v = 1'b1;
            end
            wlqe_pkg::VTX_TL0: begin
                o_result.pos_x = r_qtlx;
                o_result.pos_y = r_qtly;
                o_result.tex_u = 1'b0;
                o_result.tex_v = 1'b1;
            end
            wlqe_pkg::VTX_BL: begin
                o_result.pos_x = r_qblx;
                o_result.pos_y = r_qbly;
                o_result.tex_u = 1'b0;
                o_result.tex_v = 1'b0;
            end
            wlqe_pkg::VTX_TL1: begin
                o_result.pos_x       = r_qtlx;
                o_result.pos_y       = r_qtly;
                o_result.tex_u       = 1'b0;
                o_result.tex_v       = 1'b1;
                o_result.mid_x       = r_midx;
                o_result.mid_y       = r_midy;
                o_result.last_vertex = 1'b1;
            end
            default: begin
                o_result.pos_x = r_qtlx;
                o_result.pos_y = r_qtly;
                o_result.tex_u = 1'b0;
                o_result.tex_v = 1'b0;
            end
        endcase
    end

    // a new quad only lands when the sequencer is free or on its final vertex
    `WLQE_ASSERT_SAME(a_load_free, r_vc, !r_act || r_idx == wlqe_pkg::VTX_TL1)
    // an accepted segment holds off the next one
    `WLQE_ASSERT_NEXT(a_accept_busy, accept, busy)
    // after the final vertex the next strobe, if any, starts a fresh quad
    `WLQE_ASSERT_NEXT(a_run_restart, o_strobe && o_result.last_vertex,
                      !o_strobe || r_idx == wlqe_pkg::VTX_BR0)

endmodule
